FILE: sv/ttx_pkg.sv
package ttx_pkg;

    // one host bus transaction as it arrives
    typedef struct packed {
        logic       operation;
        logic       command_select;
        logic       register_b;
        logic [7:0] bus_data;
    } req_t;

    // one result transaction
    typedef struct packed {
        logic [7:0]  read_data;
        logic        ext_write;
        logic [10:0] ext_address;
        logic [7:0]  ext_data;
        logic [7:0]  display_control;
        logic [5:0]  first_row;
    } res_t;

    // class of a transaction as decided by the front end
    typedef enum logic [2:0] {
        KIND_READ_A,
        KIND_READ_B,
        KIND_READ_CMD,
        KIND_WRITE_A,
        KIND_COMMAND,
        KIND_DATA_B
    } item_kind_t;

    // classified transaction held in the queue between front and back
    typedef struct packed {
        item_kind_t kind;
        logic [7:0] data;
    } q_item_t;

    // command codes, bits 7..5 of a command latch B write
    typedef enum logic [2:0] {
        CMD_BEGIN_ROW,
        CMD_LOAD_ROW,
        CMD_LOAD_COL,
        CMD_ADVANCE,
        CMD_LOAD_MODE,
        CMD_LOAD_CONTROL,
        CMD_LOAD_ORIGIN,
        CMD_NOP
    } cmd_code_t;

    // data actions, bits 7..5 of the mode register
    typedef enum logic [2:0] {
        MODE_STORE_ADV,
        MODE_LOAD_ADV,
        MODE_STORE,
        MODE_LOAD,
        MODE_SLICE
    } mode_code_t;

    localparam int unsigned CELL_ADDR_W = 10;
    localparam logic [5:0]  LAST_COL_A  = 6'd39;
    localparam logic [5:0]  LAST_COL_B  = 6'd47;
    localparam logic [5:0]  LAST_COL_C  = 6'd55;
    localparam logic [5:0]  LAST_COL_D  = 6'd63;
    localparam logic [4:0]  ROW_COUNT   = 5'd24;
    localparam logic [3:0]  SLICE_COUNT = 4'd10;
    localparam logic [3:0]  LAST_SLICE  = 4'd9;

endpackage

FILE: sv/ttx_ram.sv
module ttx_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, read before write, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: sv/ttx_fifo.sv
module ttx_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_pointers_track: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

FILE: sv/ttx_front.sv
module ttx_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  ttx_pkg::req_t    request,
    input  logic             clearing,
    input  logic             q_pop,
    output logic             q_valid,
    output ttx_pkg::q_item_t q_item
);

    import ttx_pkg::*;

    q_item_t item;
    logic    q_full;
    logic    q_empty;
    logic    accept;

    // classify the bus transaction
    always_comb
    begin
        item.data = request.bus_data;
        if (!request.operation)
        begin
            if (request.command_select)
            begin
                item.kind = KIND_READ_CMD;
            end
            else if (request.register_b)
            begin
                item.kind = KIND_READ_B;
            end
            else
            begin
                item.kind = KIND_READ_A;
            end
        end
        else if (!request.register_b)
        begin
            item.kind = KIND_WRITE_A;
        end
        else if (request.command_select)
        begin
            item.kind = KIND_COMMAND;
        end
        else
        begin
            item.kind = KIND_DATA_B;
        end
    end

    // no transaction taken while the display memories are being cleared
    assign full    = q_full || clearing;
    assign accept  = push && !full;
    assign q_valid = !q_empty;

    ttx_fifo #(
        .WIDTH ($bits(q_item_t)),
        .DEPTH (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (item),
        .pop   (q_pop),
        .rdata (q_item),
        .full  (q_full),
        .empty (q_empty)
    );

endmodule

FILE: sv/ttx_back.sv
module ttx_back #(
    parameter int unsigned DISPLAY_WORDS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  ttx_pkg::q_item_t q_item,
    output logic             q_pop,
    output logic             clearing,
    input  logic             pop,
    output logic             empty,
    output ttx_pkg::res_t    result
);

    import ttx_pkg::*;

    localparam int unsigned ADDR_W = $clog2(DISPLAY_WORDS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_RUN,
        S_MEM
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [7:0]        latch_a_reg, latch_a_next;
    logic [7:0]        latch_b_reg, latch_b_next;
    logic [5:0]        col_reg, col_next;
    logic [4:0]        row_reg, row_next;
    logic [5:0]        origin_reg, origin_next;
    logic [7:0]        ctrl_reg, ctrl_next;
    logic [7:0]        mode_reg, mode_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        attr_wdata;
    logic [7:0]        char_wdata;
    logic [7:0]        attr_rdata;
    logic [7:0]        char_rdata;
    logic              res_push;
    logic              res_full;
    res_t              res_item;
    logic [10:0]       adv;
    logic [ADDR_W-1:0] cell_addr;
    logic [3:0]        slice;
    logic [3:0]        slice_after;
    logic [CELL_ADDR_W-1:0] glyph_addr;
    logic              take;

    // display memory address of a cursor position
    function automatic logic [CELL_ADDR_W-1:0] cell_of(logic [5:0] col, logic [4:0] row);
        logic [CELL_ADDR_W-1:0] a;
        if (row[4:3] == 2'b11)
        begin
            a = {2'b11, col[5:3], 2'b11, col[2:0]};
        end
        else if (col[5])
        begin
            a = {2'b11, row[2:0], row[4:3], col[2:0]};
        end
        else
        begin
            a = {row, col[4:0]};
        end
        return a;
    endfunction

    // cursor after one advance, packed as {row, col}
    function automatic logic [10:0] advance_of(logic [5:0] col, logic [4:0] row);
        logic [4:0] r;
        logic [10:0] v;
        r = row + 5'd1;
        if (col == LAST_COL_A || col == LAST_COL_B || col == LAST_COL_C || col == LAST_COL_D)
        begin
            v = {((r == ROW_COUNT) ? 5'd0 : r), 6'd0};
        end
        else
        begin
            v = {row, col + 6'd1};
        end
        return v;
    endfunction

    function automatic logic [7:0] reverse_of(logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    assign adv       = advance_of(col_reg, row_reg);
    assign cell_addr = ADDR_W'(cell_of(col_reg, row_reg));
    assign clearing  = (state_reg == S_CLEAR);
    assign take      = (state_reg == S_RUN) && q_valid && !res_full;
    assign q_pop     = take;

    // slice counter modulo ten
    assign slice       = (mode_reg[3:0] >= SLICE_COUNT) ? mode_reg[3:0] - SLICE_COUNT
                                                        : mode_reg[3:0];
    assign slice_after = (slice == LAST_SLICE) ? 4'd0 : slice + 4'd1;
    assign glyph_addr  = slice[3] ? {2'b00, char_rdata[4:0], char_rdata[6], char_rdata[5],
                                     slice[0]}
                                  : {char_rdata[6:0], slice[2:0]};

    // transaction execution
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        latch_a_next = latch_a_reg;
        latch_b_next = latch_b_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        origin_next  = origin_reg;
        ctrl_next    = ctrl_reg;
        mode_next    = mode_reg;
        ram_we       = 1'b0;
        ram_addr     = cell_addr;
        attr_wdata   = latch_a_reg;
        char_wdata   = q_item.data;
        res_push     = 1'b0;
        res_item     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_addr   = clr_reg;
                attr_wdata = '0;
                char_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DISPLAY_WORDS - 1))
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (take)
                begin
                    res_push = 1'b1;
                    unique case (q_item.kind)
                        KIND_READ_A:   res_item.read_data = latch_a_reg;
                        KIND_READ_B:   res_item.read_data = latch_b_reg;
                        KIND_READ_CMD: res_item.read_data = '0;
                        KIND_WRITE_A:  latch_a_next = q_item.data;
                        KIND_COMMAND:
                        begin
                            latch_b_next = q_item.data;
                            unique case (cmd_code_t'(q_item.data[7:5]))
                                CMD_BEGIN_ROW:
                                begin
                                    col_next = '0;
                                    row_next = latch_a_reg[4:0];
                                end
                                CMD_LOAD_ROW:     row_next    = latch_a_reg[4:0];
                                CMD_LOAD_COL:     col_next    = latch_a_reg[5:0];
                                CMD_ADVANCE:      {row_next, col_next} = adv;
                                CMD_LOAD_MODE:    mode_next   = latch_a_reg;
                                CMD_LOAD_CONTROL: ctrl_next   = latch_a_reg;
                                CMD_LOAD_ORIGIN:  origin_next = latch_a_reg[5:0];
                                CMD_NOP:          ;
                                default:          ;
                            endcase
                        end
                        KIND_DATA_B:
                        begin
                            latch_b_next = q_item.data;
                            unique case (mode_code_t'(mode_reg[7:5])) inside
                                MODE_STORE_ADV:
                                begin
                                    ram_we = 1'b1;
                                    {row_next, col_next} = adv;
                                end
                                MODE_STORE:
                                begin
                                    ram_we = 1'b1;
                                end
                                MODE_LOAD_ADV, MODE_LOAD, MODE_SLICE:
                                begin
                                    // result follows once the read data is back
                                    res_push   = 1'b0;
                                    state_next = S_MEM;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_MEM:
            begin
                res_push   = 1'b1;
                state_next = S_RUN;
                unique case (mode_code_t'(mode_reg[7:5])) inside
                    MODE_LOAD_ADV, MODE_LOAD:
                    begin
                        latch_a_next = attr_rdata;
                        latch_b_next = char_rdata;
                        if (mode_reg[7:5] == MODE_LOAD_ADV)
                        begin
                            {row_next, col_next} = adv;
                        end
                    end
                    MODE_SLICE:
                    begin
                        if (char_rdata[7] && (char_rdata[6] || char_rdata[5]))
                        begin
                            res_item.ext_write   = 1'b1;
                            res_item.ext_address = {attr_rdata[7], glyph_addr};
                            res_item.ext_data    = reverse_of(latch_a_reg);
                        end
                        mode_next = {mode_reg[7:4], slice_after};
                    end
                    default: ;
                endcase
            end
            default: state_next = S_RUN;
        endcase

        res_item.display_control = ctrl_next;
        res_item.first_row       = origin_next;
    end

    // state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            latch_a_reg <= '0;
            latch_b_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            origin_reg  <= '0;
            ctrl_reg    <= '0;
            mode_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            latch_a_reg <= latch_a_next;
            latch_b_reg <= latch_b_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            origin_reg  <= origin_next;
            ctrl_reg    <= ctrl_next;
            mode_reg    <= mode_next;
        end
    end

    ttx_ram #(
        .WIDTH (8),
        .DEPTH (DISPLAY_WORDS)
    ) u_attr_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (attr_wdata),
        .rdata (attr_rdata)
    );

    ttx_ram #(
        .WIDTH (8),
        .DEPTH (DISPLAY_WORDS)
    ) u_char_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (char_wdata),
        .rdata (char_rdata)
    );

    // result queue decouples the host read side
    ttx_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_item),
        .pop   (pop),
        .rdata (result),
        .full  (res_full),
        .empty (empty)
    );

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !res_push)
        else $error("result produced during memory clear");

    a_ext_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_item.ext_write) |-> (state_reg == S_MEM))
        else $error("external write without memory read");

    a_mem_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEM) |=> (state_reg == S_RUN))
        else $error("memory wait longer than one cycle");

    a_slice_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEM && mode_reg[7:5] == MODE_SLICE) |=> (mode_reg[3:0] < SLICE_COUNT))
        else $error("slice counter out of range");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

endmodule

FILE: sv/teletext_display_bus_interface.sv
// flow: an accepted transaction is held in the front queue, then executed into the result queue;
//   load and slice actions first read the display memories and finish in the S_MEM state
// throughput: one transaction per cycle while the result queue has room; those that read the
//   display memories hold the back end in S_MEM, as both single-port RAMs share one address
// reset: all registers zero; then a pass over all DISPLAY_WORDS addresses clears both display memories, full is high
module teletext_display_bus_interface #(
    parameter int unsigned DISPLAY_WORDS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  ttx_pkg::req_t request,
    output logic          empty,
    input  logic          pop,
    output ttx_pkg::res_t result
);

    import ttx_pkg::*;

    logic    clearing;
    logic    q_pop;
    logic    q_valid;
    q_item_t q_item;

    // front end: take and classify bus transactions
    ttx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .clearing (clearing),
        .q_pop    (q_pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    // back end: registers, display memories, result queue
    ttx_back #(
        .DISPLAY_WORDS (DISPLAY_WORDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule
